[hdl/assert_macros.svh]
// Shared concurrent assertion forms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[hdl/sfa_pkg.sv]
`timescale 1ns / 1ps
package sfa_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int BLK_W       = ADDR_BITS - 4;
  localparam int NUM_LEVELS  = 32;
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int SUB_W       = 3;
  localparam int CLS_W       = LVL_W + SUB_W;
  localparam int NUM_CLASSES = NUM_LEVELS * 8;
  localparam int STACK_DEPTH = 16;
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW      = CLS_W + STK_IDX_W;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_ADD   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [32:0] granted_size;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic srch;
    logic srch2;
    logic pop_rd;
    logic pop_cnt;
    logic pop_dat;
    logic carve;
    logic push_rd;
    logic push_wr;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  hit_here;
    logic  hit_higher;
    logic  split;
    logic  carve_more;
    logic  carving;
  } sts_t;

  typedef struct packed {
    logic [31:0]      piece;
    logic [LVL_W-1:0] lvl;
    logic [SUB_W-1:0] sub;
  } piece_t;

  function automatic logic [LVL_W-1:0] msb_idx(input logic [31:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] lsb_idx32(input logic [31:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [SUB_W-1:0] lsb_idx8(input logic [7:0] v);
    logic [SUB_W-1:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = SUB_W'(i);
    end
    return r;
  endfunction

  // 2^l + 2^(l-3) * (1 + s)
  function automatic logic [32:0] class_bytes(input logic [LVL_W-1:0] l,
                                              input logic [SUB_W-1:0] s);
    logic [32:0] a;
    logic [32:0] b;
    a = 33'd1 << l;
    b = 33'({1'b0, s} + 4'd1) << (l - LVL_W'(3));
    return a + b;
  endfunction

  // largest class piece from the top four significant bits of a region size
  function automatic piece_t carve_piece(input logic [31:0] size);
    piece_t           p;
    logic [LVL_W-1:0] t;
    logic [31:0]      pm1;
    t       = msb_idx(size);
    p.piece = size & ({32{1'b1}} << (t - LVL_W'(3)));
    pm1     = p.piece - 32'd1;
    p.lvl   = (p.piece == (32'd1 << t)) ? t - LVL_W'(1) : t;
    p.sub   = SUB_W'(pm1 >> (p.lvl - LVL_W'(3)));
    return p;
  endfunction

endpackage

[hdl/sfa_ram.sv]
`timescale 1ns / 1ps
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sfa_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output sfa_pkg::cmd_t cmd,
  input  sfa_pkg::sts_t sts
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DEC     = 11'b00000000010,
    S_SRCH    = 11'b00000000100,
    S_SRCH2   = 11'b00000001000,
    S_POP_RD  = 11'b00000010000,
    S_POP_CNT = 11'b00000100000,
    S_POP_DAT = 11'b00001000000,
    S_CARVE   = 11'b00010000000,
    S_PUSH_RD = 11'b00100000000,
    S_PUSH_WR = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DEC;
      end
      S_DEC: begin
        unique case (sts.mode)
          sfa_pkg::MODE_ALLOC: state_nxt = S_SRCH;
          sfa_pkg::MODE_FREE:  state_nxt = S_PUSH_RD;
          sfa_pkg::MODE_ADD:   state_nxt = S_CARVE;
          sfa_pkg::MODE_NONE:  state_nxt = S_DONE;
        endcase
      end
      S_SRCH: begin
        priority if (sts.hit_here) state_nxt = S_POP_RD;
        else if (sts.hit_higher)   state_nxt = S_SRCH2;
        else                       state_nxt = S_DONE;
      end
      S_SRCH2:   state_nxt = S_POP_RD;
      S_POP_RD:  state_nxt = S_POP_CNT;
      S_POP_CNT: state_nxt = S_POP_DAT;
      S_POP_DAT: state_nxt = sts.split ? S_CARVE : S_DONE;
      S_CARVE:   state_nxt = sts.carve_more ? S_PUSH_RD : S_DONE;
      S_PUSH_RD: state_nxt = S_PUSH_WR;
      S_PUSH_WR: state_nxt = sts.carving ? S_CARVE : S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.dec     = (state_r == S_DEC);
  assign cmd.srch    = (state_r == S_SRCH);
  assign cmd.srch2   = (state_r == S_SRCH2);
  assign cmd.pop_rd  = (state_r == S_POP_RD);
  assign cmd.pop_cnt = (state_r == S_POP_CNT);
  assign cmd.pop_dat = (state_r == S_POP_DAT);
  assign cmd.carve   = (state_r == S_CARVE);
  assign cmd.push_rd = (state_r == S_PUSH_RD);
  assign cmd.push_wr = (state_r == S_PUSH_WR);

  `ASSERT_NEXT(a_accept_dec, clk, rst_n, start && !busy, state_r == S_DEC)
  `ASSERT_NEXT(a_done_once, clk, rst_n, out_valid, !out_valid && !busy)

endmodule

[hdl/sfa_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfa_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sfa_pkg::in_word_t   in_word,
  input  sfa_pkg::cmd_t       cmd,
  output sfa_pkg::sts_t       sts,
  output sfa_pkg::out_word_t  out_word
);

  localparam int LW = sfa_pkg::LVL_W;
  localparam int SW = sfa_pkg::SUB_W;
  localparam int CW = sfa_pkg::CLS_W;
  localparam int BW = sfa_pkg::BLK_W;
  localparam int NW = sfa_pkg::CNT_W;
  localparam int IW = sfa_pkg::STK_IDX_W;

  // request latch
  logic [1:0]  mode_r,  mode_nxt;
  logic [31:0] req_r,   req_nxt;
  logic [BW-1:0] addr_r, addr_nxt;
  // allocate target and hit
  logic [LW-1:0] lvl_r, lvl_nxt, flvl_r, flvl_nxt;
  logic [SW-1:0] sub_r, sub_nxt, fsub_r, fsub_nxt;
  logic [32:0]   want_r, want_nxt, span_r, span_nxt;
  logic          exact_r, exact_nxt, cnt_pos_r, cnt_pos_nxt;
  // carve / push
  logic [BW-1:0] csize_r, csize_nxt, padr_r, padr_nxt;
  logic [CW-1:0] pcls_r, pcls_nxt;
  logic          carving_r, carving_nxt;
  // result
  logic [31:0] g_addr_r, g_addr_nxt;
  logic [32:0] g_size_r, g_size_nxt;
  logic [1:0]  status_r, status_nxt;
  // free-list bitmaps
  logic [sfa_pkg::NUM_LEVELS-1:0] class_bits_r, class_bits_nxt;
  logic [7:0] sub_bits_r   [sfa_pkg::NUM_LEVELS];
  logic [7:0] sub_bits_nxt [sfa_pkg::NUM_LEVELS];
  logic [sfa_pkg::NUM_CLASSES-1:0] cnt_vld_r, cnt_vld_nxt;
  logic cnt_rvld_r;

  logic [32:0]   rnd;
  logic [31:0]   sm1;
  logic [LW-1:0] dlvl, bm_idx;
  logic [SW-1:0] dsub;
  logic [7:0]    sb, here_bits;
  logic [31:0]   hi_bits;
  logic          hit_here, hit_higher, split;
  logic [32:0]   rem;
  logic [BW-1:0] blk;
  sfa_pkg::piece_t pc;

  logic [CW-1:0]  cls_sel;
  logic           cnt_we;
  logic [NW-1:0]  cnt_wdata, cnt_rdata, cnt_cur, cnt_dec;
  logic           stk_we;
  logic [sfa_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
  logic [BW-1:0]  stk_rdata;

  always_comb begin
    rnd = ({1'b0, req_r} + 33'd15) & ~33'd15;
    if (rnd == 33'd0) rnd = 33'd16;
    sm1  = 32'(rnd - 33'd1);
    dlvl = sfa_pkg::msb_idx(sm1);
    dsub = SW'(sm1 >> (dlvl - LW'(3)));

    priority if (cmd.srch) bm_idx = lvl_r;
    else if (cmd.push_rd)  bm_idx = pcls_r[CW-1:SW];
    else                   bm_idx = flvl_r;
    sb = sub_bits_r[bm_idx];

    here_bits  = class_bits_r[lvl_r] ? (sb & (8'hFF << sub_r)) : 8'd0;
    hit_here   = (here_bits != 8'd0);
    hi_bits    = class_bits_r & ~((32'd2 << lvl_r) - 32'd1);
    hit_higher = (hi_bits != 32'd0);

    cls_sel = (cmd.pop_rd || cmd.pop_cnt) ? {flvl_r, fsub_r} : pcls_r;
    cnt_cur = cnt_rvld_r ? cnt_rdata : '0;
    cnt_dec = cnt_cur - NW'(1);
    split   = !exact_r && (span_r > want_r);
    rem     = span_r - want_r;
    blk     = cnt_pos_r ? stk_rdata : '0;
    pc      = sfa_pkg::carve_piece({csize_r, 4'b0000});
  end

  always_comb begin
    mode_nxt = mode_r;  req_nxt = req_r;  addr_nxt = addr_r;
    lvl_nxt = lvl_r;  sub_nxt = sub_r;  flvl_nxt = flvl_r;  fsub_nxt = fsub_r;
    want_nxt = want_r;  span_nxt = span_r;
    exact_nxt = exact_r;  cnt_pos_nxt = cnt_pos_r;
    csize_nxt = csize_r;  padr_nxt = padr_r;  pcls_nxt = pcls_r;
    carving_nxt = carving_r;
    g_addr_nxt = g_addr_r;  g_size_nxt = g_size_r;  status_nxt = status_r;
    class_bits_nxt = class_bits_r;
    sub_bits_nxt   = sub_bits_r;
    cnt_vld_nxt    = cnt_vld_r;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_dec;
    stk_we    = 1'b0;

    if (cmd.load) begin
      mode_nxt = in_word.mode;
      req_nxt  = in_word.request_size;
      addr_nxt = in_word.block_address[31:4];
    end

    if (cmd.dec) begin
      lvl_nxt     = dlvl;
      sub_nxt     = dsub;
      want_nxt    = sfa_pkg::class_bytes(dlvl, dsub);
      pcls_nxt    = {dlvl, dsub};
      padr_nxt    = addr_r;
      csize_nxt   = req_r[31:4];
      carving_nxt = (mode_r == sfa_pkg::MODE_ADD);
      g_addr_nxt  = '0;
      g_size_nxt  = '0;
      status_nxt  = sfa_pkg::ST_OK;
    end

    if (cmd.srch) begin
      exact_nxt = class_bits_r[lvl_r] & sb[sub_r];
      flvl_nxt  = hit_here ? lvl_r : sfa_pkg::lsb_idx32(hi_bits);
      fsub_nxt  = sfa_pkg::lsb_idx8(here_bits);
      if (!hit_here && !hit_higher) status_nxt = sfa_pkg::ST_NOFIT;
    end

    if (cmd.srch2) fsub_nxt = sfa_pkg::lsb_idx8(sb);

    if (cmd.pop_rd) span_nxt = sfa_pkg::class_bytes(flvl_r, fsub_r);

    if (cmd.pop_cnt) begin
      cnt_pos_nxt = (cnt_cur != '0);
      cnt_we      = (cnt_cur != '0);
      // class empties: clear its bit, and the level bit once no subclass is left
      if (cnt_cur <= NW'(1)) begin
        sub_bits_nxt[flvl_r][fsub_r] = 1'b0;
        if ((sb & ~(8'd1 << fsub_r)) == 8'd0) class_bits_nxt[flvl_r] = 1'b0;
      end
    end

    if (cmd.pop_dat) begin
      g_addr_nxt = {blk, 4'b0000};
      g_size_nxt = want_r;
      if (split) begin
        csize_nxt   = rem[31:4];
        addr_nxt    = blk + want_r[31:4];
        carving_nxt = 1'b1;
      end
    end

    if (cmd.carve && (csize_r != '0)) begin
      pcls_nxt  = {pc.lvl, pc.sub};
      padr_nxt  = addr_r;
      addr_nxt  = addr_r + pc.piece[31:4];
      csize_nxt = csize_r - pc.piece[31:4];
    end

    if (cmd.push_rd) begin
      sub_bits_nxt[bm_idx][pcls_r[SW-1:0]] = 1'b1;
      class_bits_nxt[bm_idx]               = 1'b1;
    end

    if (cmd.push_wr) begin
      if (cnt_cur >= NW'(sfa_pkg::STACK_DEPTH)) begin
        status_nxt = sfa_pkg::ST_OVF;
      end else begin
        stk_we    = 1'b1;
        cnt_we    = 1'b1;
        cnt_wdata = cnt_cur + NW'(1);
      end
    end

    if (cnt_we) cnt_vld_nxt[cls_sel] = 1'b1;
  end

  assign stk_waddr = {pcls_r, cnt_cur[IW-1:0]};
  assign stk_raddr = {flvl_r, fsub_r, cnt_dec[IW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_bits_r <= '0;
      sub_bits_r   <= '{default: '0};
      cnt_vld_r    <= '0;
      cnt_rvld_r   <= 1'b0;
      flvl_r       <= '0;
    end else begin
      class_bits_r <= class_bits_nxt;
      sub_bits_r   <= sub_bits_nxt;
      cnt_vld_r    <= cnt_vld_nxt;
      cnt_rvld_r   <= cnt_vld_r[cls_sel];
      flvl_r       <= flvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;  req_r <= req_nxt;  addr_r <= addr_nxt;
    lvl_r <= lvl_nxt;  sub_r <= sub_nxt;  fsub_r <= fsub_nxt;
    want_r <= want_nxt;  span_r <= span_nxt;
    exact_r <= exact_nxt;  cnt_pos_r <= cnt_pos_nxt;
    csize_r <= csize_nxt;  padr_r <= padr_nxt;  pcls_r <= pcls_nxt;
    carving_r <= carving_nxt;
    g_addr_r <= g_addr_nxt;  g_size_r <= g_size_nxt;  status_r <= status_nxt;
  end

  sfa_ram #(.WIDTH(NW), .DEPTH(sfa_pkg::NUM_CLASSES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cls_sel),
    .wdata (cnt_wdata),
    .raddr (cls_sel),
    .rdata (cnt_rdata)
  );

  sfa_ram #(.WIDTH(BW), .DEPTH(sfa_pkg::NUM_CLASSES * sfa_pkg::STACK_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (padr_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign sts.mode       = sfa_pkg::mode_t'(mode_r);
  assign sts.hit_here   = hit_here;
  assign sts.hit_higher = hit_higher;
  assign sts.split      = split;
  assign sts.carve_more = (csize_r != '0);
  assign sts.carving    = carving_r;

  assign out_word.granted_address = g_addr_r;
  assign out_word.granted_size    = g_size_r;
  assign out_word.status          = status_r;

  `ASSERT_IMPL(a_bitmap_sync, clk, rst_n, 1'b1,
               class_bits_r[bm_idx] == (sub_bits_r[bm_idx] != 8'd0))
  `ASSERT_IMPL(a_pop_nonempty, clk, rst_n, cmd.pop_cnt, cnt_cur != '0)

endmodule

[hdl/segregated_fit_allocator.sv]
`timescale 1ns / 1ps
// One word at a time; out_valid strobes in the cycle after the last step, and the next start is taken back in idle.
// Free pushes the block; an unused mode goes from decode to done; no fit ends after the search; allocate
// pops a block (searching a larger level if needed) and carves any surplus, add region the whole region.
// Each class piece costs one count-RAM read/write pair and one stack-RAM write.
// Synchronous active-low reset clears the FSM, bitmaps and count valid bits; no clearing pass.
// Results cannot be stalled by the receiver.
module segregated_fit_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sfa_pkg::in_word_t  in_word,
  output logic               out_valid,
  output sfa_pkg::out_word_t out_word
);

  sfa_pkg::cmd_t cmd;
  sfa_pkg::sts_t sts;

  sfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  sfa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule
